FILE: hdl/point_triangle_closest_point_unit_defines.svh
// Assertion macros for the closest point unit checker.
// No dependencies; included by the checker only.
`ifndef POINT_TRIANGLE_CLOSEST_POINT_UNIT_DEFINES_SVH
`define POINT_TRIANGLE_CLOSEST_POINT_UNIT_DEFINES_SVH

// checked outside reset
`define PTCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PTCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/ptcp_pkg.sv
// Shared types, constants and helpers of the closest point unit.
// No dependencies; used by the divider and the top level through scoped names.
`timescale 1ns / 1ps

package ptcp_pkg;

  typedef logic signed [31:0] coord_t;
  typedef coord_t vec_t [3];

  localparam logic [62:0] DMAX     = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [32:0] SQ_LIMIT = 33'h0_B504_F333;

  localparam logic [2:0] CFG_QUERY_X = 3'd0;
  localparam logic [2:0] CFG_QUERY_Y = 3'd1;
  localparam logic [2:0] CFG_QUERY_Z = 3'd2;
  localparam logic [2:0] CFG_START_X = 3'd3;
  localparam logic [2:0] CFG_START_Y = 3'd4;
  localparam logic [2:0] CFG_START_Z = 3'd5;
  localparam logic [2:0] CFG_START_D = 3'd6;

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_LOAD = 20'h00002,
    S_CRN  = 20'h00004,
    S_DNN  = 20'h00008,
    S_DWN  = 20'h00010,
    S_DIVT = 20'h00020,
    S_PROJ = 20'h00040,
    S_SQP  = 20'h00080,
    S_CHK  = 20'h00100,
    S_ESET = 20'h00200,
    S_EVEC = 20'h00400,
    S_CRE  = 20'h00800,
    S_DCN  = 20'h01000,
    S_DLL  = 20'h02000,
    S_DLR  = 20'h04000,
    S_DIVP = 20'h08000,
    S_EPT  = 20'h10000,
    S_SQD  = 20'h20000,
    S_UPD  = 20'h40000,
    S_FIN  = 20'h80000
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] u;
    logic [63:0] d;
    logic [32:0] cap;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] q;
  } div_rsp_t;

  // cross product term order: x = a1b2 - a2b1, y = a2b0 - a0b2, z = a0b1 - a1b0
  function automatic logic [2:0] cross_a(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd0;
      3'd4:    r = 3'd0;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] cross_b(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0:    r = 3'd2;
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd0;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic coord_t pick(input vec_t v, input logic [2:0] k);
    coord_t r;
    case (k)
      3'd0:    r = v[0];
      3'd1:    r = v[1];
      default: r = v[2];
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/ptcp_mul.sv
// Shared 33x33 signed multiplier with registered product.
// No dependencies.
`timescale 1ns / 1ps

module ptcp_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 66'(a_i) * 66'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: hdl/ptcp_div.sv
// Bit-serial restoring divider: min(floor(u * 2^FRAC_BITS / d), cap).
// Depends on ptcp_pkg (request and response structs).
`timescale 1ns / 1ps

module ptcp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptcp_pkg::div_req_t req_i,
  output ptcp_pkg::div_rsp_t rsp_o
);

  localparam int NB    = 64 + FRAC_BITS;
  localparam int CNT_W = $clog2(NB);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NB-1:0]    num_q, num_d;
  logic [64:0]      rem_q, rem_d;
  logic [33:0]      quo_q, quo_d;
  logic             ovf_q, ovf_d;
  logic [63:0]      den_q, den_d;
  logic [32:0]      cap_q, cap_d;

  logic [64:0] r_sh;
  logic        ge;
  logic [33:0] q_nx;

  always_comb begin
    r_sh = {rem_q[63:0], num_q[NB-1]};
    ge   = r_sh >= {1'b0, den_q};
    q_nx = {quo_q[32:0], ge};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    den_d  = den_q;
    cap_d  = cap_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = {req_i.u, {FRAC_BITS{1'b0}}};
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
      den_d  = req_i.d;
      cap_d  = req_i.cap;
    end else if (busy_q) begin
      num_d = {num_q[NB-2:0], 1'b0};
      rem_d = ge ? r_sh - {1'b0, den_q} : r_sh;
      if (!ovf_q) begin
        if (q_nx > {1'b0, cap_q}) begin
          ovf_d = 1'b1;
        end else begin
          quo_d = q_nx;
        end
      end
      if (cnt_q == CNT_W'(NB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
    den_q <= den_d;
    cap_q <= cap_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = ovf_q ? cap_q : quo_q[32:0];

endmodule

FILE: hdl/point_triangle_closest_point_unit.sv
// Paths to a result, shortest first: a degenerate triangle, one that the plane distance rejects,
// and at worst one inside edge and two outside edges that divide.
// Each division runs 64+FRAC_BITS bit-serial steps plus start and done.
// One word at a time: tready is high only in idle, so a new triangle word is taken only once
// the last result word is registered; a stalled result word holds the unit in its final state.
// Reset: async active low; query/start regs and best point to 0, distances to 2^63-1.
`timescale 1ns / 1ps

module point_triangle_closest_point_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z
  input  logic [287:0] s_axis_tdata,
  // first_of_query
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // best_x, best_y, best_z, best_dist_sq, one pad bit
  output logic [159:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [62:0]  cfg_data_i
);

  localparam logic signed [65:0] CMAX  = 66'((66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1);
  localparam logic signed [65:0] CMIN  = -CMAX - 66'sd1;
  localparam logic signed [32:0] ONE   = 33'(64'd1 << FRAC_BITS);
  localparam logic [32:0]        CAP_T = 33'(CMAX + 66'sd1);

  function automatic ptcp_pkg::coord_t sat_c(input logic signed [65:0] v);
    ptcp_pkg::coord_t r;
    if (v > CMAX) r = CMAX[31:0];
    else if (v < CMIN) r = CMIN[31:0];
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [65:0] sx(input logic [31:0] x);
    return {{34{x[31]}}, x};
  endfunction

  function automatic logic signed [32:0] x33(input logic [31:0] x);
    return {x[31], x};
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] d);
    return d[32] ? 33'(-d) : d;
  endfunction

  ptcp_pkg::state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] edge_q, edge_d;
  logic [1:0] outs_q, outs_d;
  logic       ovld_q, ovld_d;

  logic [31:0] qr_q [3];
  logic [31:0] qr_d [3];
  logic [31:0] sr_q [3];
  logic [31:0] sr_d [3];
  logic [62:0] sd_q, sd_d;

  ptcp_pkg::vec_t best_q, best_d;
  logic [62:0]    bestd_q, bestd_d;

  ptcp_pkg::vec_t va_q, va_d, vb_q, vb_d, vc_q, vc_d;
  ptcp_pkg::vec_t ab_q, ab_d, ac_q, ac_d, w_q, w_d, n_q, n_d;
  ptcp_pkg::vec_t proj_q, proj_d, p_q, p_d, v1_q, v1_d, v2_q, v2_d;
  ptcp_pkg::vec_t e1_q, e1_d, e2_q, e2_d, cr_q, cr_d, ln_q, ln_d, rel_q, rel_d;
  ptcp_pkg::vec_t c_q, c_d;
  ptcp_pkg::coord_t   t_q, t_d;
  logic signed [32:0] prm_q, prm_d;
  logic signed [65:0] acc_q, acc_d, den_q, den_d, num_q, num_d;
  logic signed [65:0] lensq_q, lensq_d, numer_q, numer_d;
  logic [62:0]        plane_q, plane_d, sqacc_q, sqacc_d;
  logic [159:0]       out_q, out_d;

  ptcp_pkg::vec_t     qv;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod, fm, dsum, tq, nabs;
  logic [2:0]         cc, ka, kb, nops;
  logic               is_mul;
  logic signed [32:0] sq_iss, sq_con;
  logic [32:0]        mag_iss, mag_con;
  logic [62:0]        sbase, sval, sqsum;
  ptcp_pkg::div_req_t div_req;
  ptcp_pkg::div_rsp_t div_rsp;

  ptcp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ptcp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) qv[i] = sat_c(sx(qr_q[i]));
  end

  assign cc   = cnt_q - 3'd1;
  assign ka   = ptcp_pkg::cross_a(cnt_q);
  assign kb   = ptcp_pkg::cross_b(cnt_q);
  assign fm   = prod >>> FRAC_BITS;
  assign dsum = ((cc == 3'd0) ? 66'sd0 : acc_q) + fm;
  assign tq   = $signed({33'd0, div_rsp.q});
  assign nabs = num_q[65] ? -num_q : num_q;

  assign sq_iss  = (state_q == ptcp_pkg::S_SQP) ? x33(ptcp_pkg::pick(proj_q, cnt_q))
                 : x33(ptcp_pkg::pick(c_q, cnt_q)) - x33(ptcp_pkg::pick(qv, cnt_q));
  assign sq_con  = (state_q == ptcp_pkg::S_SQP) ? x33(ptcp_pkg::pick(proj_q, cc))
                 : x33(ptcp_pkg::pick(c_q, cc)) - x33(ptcp_pkg::pick(qv, cc));
  assign mag_iss = mag33(sq_iss);
  assign mag_con = mag33(sq_con);
  assign sbase   = (cc == 3'd0) ? 63'd0 : sqacc_q;
  assign sval    = (mag_con > ptcp_pkg::SQ_LIMIT) ? ptcp_pkg::DMAX : prod[62:0];
  assign sqsum   = (sval > ptcp_pkg::DMAX - sbase) ? ptcp_pkg::DMAX : sbase + sval;

  always_comb begin
    is_mul = 1'b1;
    nops   = 3'd3;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ptcp_pkg::S_CRN: begin
        nops  = 3'd6;
        mul_a = x33(ptcp_pkg::pick(ab_q, ka));
        mul_b = x33(ptcp_pkg::pick(ac_q, kb));
      end
      ptcp_pkg::S_CRE: begin
        nops  = 3'd6;
        mul_a = x33(ptcp_pkg::pick(e1_q, ka));
        mul_b = x33(ptcp_pkg::pick(e2_q, kb));
      end
      ptcp_pkg::S_DNN: begin
        mul_a = x33(ptcp_pkg::pick(n_q, cnt_q));
        mul_b = x33(ptcp_pkg::pick(n_q, cnt_q));
      end
      ptcp_pkg::S_DWN: begin
        mul_a = x33(ptcp_pkg::pick(w_q, cnt_q));
        mul_b = x33(ptcp_pkg::pick(n_q, cnt_q));
      end
      ptcp_pkg::S_PROJ: begin
        mul_a = x33(ptcp_pkg::pick(n_q, cnt_q));
        mul_b = x33(t_q);
      end
      ptcp_pkg::S_DCN: begin
        mul_a = x33(ptcp_pkg::pick(cr_q, cnt_q));
        mul_b = x33(ptcp_pkg::pick(n_q, cnt_q));
      end
      ptcp_pkg::S_DLL: begin
        mul_a = x33(ptcp_pkg::pick(ln_q, cnt_q));
        mul_b = x33(ptcp_pkg::pick(ln_q, cnt_q));
      end
      ptcp_pkg::S_DLR: begin
        mul_a = x33(ptcp_pkg::pick(ln_q, cnt_q));
        mul_b = x33(ptcp_pkg::pick(rel_q, cnt_q));
      end
      ptcp_pkg::S_EPT: begin
        mul_a = x33(ptcp_pkg::pick(v2_q, cnt_q)) - x33(ptcp_pkg::pick(v1_q, cnt_q));
        mul_b = prm_q;
      end
      ptcp_pkg::S_SQP, ptcp_pkg::S_SQD: begin
        mul_a = $signed(mag_iss);
        mul_b = $signed(mag_iss);
      end
      default: is_mul = 1'b0;
    endcase
  end

  always_comb begin
    div_req.start = ((state_q == ptcp_pkg::S_DIVT) || (state_q == ptcp_pkg::S_DIVP))
                    && (cnt_q == 3'd0);
    if (state_q == ptcp_pkg::S_DIVP) begin
      div_req.u   = numer_q[63:0];
      div_req.d   = lensq_q[63:0];
      div_req.cap = ONE;
    end else begin
      div_req.u   = nabs[63:0];
      div_req.d   = den_q[63:0];
      div_req.cap = CAP_T;
    end
  end

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  edge_d = edge_q;  outs_d = outs_q;
    ovld_d  = ovld_q;   qr_d  = qr_q;   sr_d   = sr_q;    sd_d   = sd_q;
    best_d  = best_q;   bestd_d = bestd_q;
    va_d = va_q;  vb_d = vb_q;  vc_d = vc_q;  ab_d = ab_q;  ac_d = ac_q;  w_d = w_q;
    n_d = n_q;  proj_d = proj_q;  p_d = p_q;  v1_d = v1_q;  v2_d = v2_q;
    e1_d = e1_q;  e2_d = e2_q;  cr_d = cr_q;  ln_d = ln_q;  rel_d = rel_q;  c_d = c_q;
    t_d = t_q;  prm_d = prm_q;  acc_d = acc_q;  den_d = den_q;  num_d = num_q;
    lensq_d = lensq_q;  numer_d = numer_q;  plane_d = plane_q;  sqacc_d = sqacc_q;
    out_d = out_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptcp_pkg::CFG_QUERY_X: qr_d[0] = cfg_data_i[31:0];
        ptcp_pkg::CFG_QUERY_Y: qr_d[1] = cfg_data_i[31:0];
        ptcp_pkg::CFG_QUERY_Z: qr_d[2] = cfg_data_i[31:0];
        ptcp_pkg::CFG_START_X: sr_d[0] = cfg_data_i[31:0];
        ptcp_pkg::CFG_START_Y: sr_d[1] = cfg_data_i[31:0];
        ptcp_pkg::CFG_START_Z: sr_d[2] = cfg_data_i[31:0];
        ptcp_pkg::CFG_START_D: sd_d    = cfg_data_i;
        default: ;
      endcase
    end

    if (ovld_q && m_axis_tready) ovld_d = 1'b0;

    // word consume of the previous cycle's product
    if (is_mul && (cnt_q != 3'd0)) begin
      unique case (state_q)
        ptcp_pkg::S_CRN: begin
          if (!cc[0]) acc_d = fm;
          else n_d[cc[2:1]] = sat_c(acc_q - fm);
        end
        ptcp_pkg::S_CRE: begin
          if (!cc[0]) acc_d = fm;
          else cr_d[cc[2:1]] = sat_c(acc_q - fm);
        end
        ptcp_pkg::S_PROJ: proj_d[cc[1:0]] = sat_c(fm);
        ptcp_pkg::S_EPT:
          c_d[cc[1:0]] = sat_c(sx(ptcp_pkg::pick(v1_q, cc)) + fm);
        ptcp_pkg::S_SQP, ptcp_pkg::S_SQD: sqacc_d = sqsum;
        default: acc_d = dsum;
      endcase
    end

    unique case (state_q)
      ptcp_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            va_d[i] = sat_c(sx(s_axis_tdata[32*i +: 32]));
            vb_d[i] = sat_c(sx(s_axis_tdata[96 + 32*i +: 32]));
            vc_d[i] = sat_c(sx(s_axis_tdata[192 + 32*i +: 32]));
          end
          if (s_axis_tuser[0]) begin
            for (int i = 0; i < 3; i++) best_d[i] = sat_c(sx(sr_q[i]));
            bestd_d = sd_q;
          end
          state_d = ptcp_pkg::S_LOAD;
        end
      end
      ptcp_pkg::S_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          ab_d[i] = sat_c(sx(vb_q[i]) - sx(va_q[i]));
          ac_d[i] = sat_c(sx(vc_q[i]) - sx(va_q[i]));
          w_d[i]  = sat_c(sx(va_q[i]) - sx(qv[i]));
        end
        cnt_d   = '0;
        state_d = ptcp_pkg::S_CRN;
      end
      ptcp_pkg::S_DIVT, ptcp_pkg::S_DIVP: begin
        if (cnt_q == 3'd0) begin
          cnt_d = 3'd1;
        end else if (div_rsp.done) begin
          cnt_d = '0;
          if (state_q == ptcp_pkg::S_DIVT) begin
            t_d     = sat_c(num_q[65] ? -tq : tq);
            state_d = ptcp_pkg::S_PROJ;
          end else begin
            prm_d   = $signed(div_rsp.q);
            state_d = ptcp_pkg::S_EPT;
          end
        end
      end
      ptcp_pkg::S_CHK: begin
        plane_d = sqacc_q;
        if (sqacc_q <= bestd_q) begin
          for (int i = 0; i < 3; i++) p_d[i] = sat_c(sx(qv[i]) + sx(proj_q[i]));
          edge_d  = '0;
          outs_d  = '0;
          state_d = ptcp_pkg::S_ESET;
        end else begin
          state_d = ptcp_pkg::S_FIN;
        end
      end
      ptcp_pkg::S_ESET: begin
        if ((edge_q == 2'd3) || (outs_q == 2'd2)) begin
          if (outs_q == 2'd0) begin
            best_d  = p_q;
            bestd_d = plane_q;
          end
          state_d = ptcp_pkg::S_FIN;
        end else begin
          unique case (edge_q)
            2'd0:    begin v1_d = va_q; v2_d = vb_q; end
            2'd1:    begin v1_d = vb_q; v2_d = vc_q; end
            default: begin v1_d = vc_q; v2_d = va_q; end
          endcase
          state_d = ptcp_pkg::S_EVEC;
        end
      end
      ptcp_pkg::S_EVEC: begin
        for (int i = 0; i < 3; i++) begin
          e1_d[i]  = sat_c(sx(v1_q[i]) - sx(p_q[i]));
          e2_d[i]  = sat_c(sx(v2_q[i]) - sx(p_q[i]));
          ln_d[i]  = sat_c(sx(v2_q[i]) - sx(v1_q[i]));
          rel_d[i] = sat_c(sx(p_q[i]) - sx(v1_q[i]));
        end
        cnt_d   = '0;
        state_d = ptcp_pkg::S_CRE;
      end
      ptcp_pkg::S_UPD: begin
        if (sqacc_q < bestd_q) begin
          best_d  = c_q;
          bestd_d = sqacc_q;
        end
        edge_d  = edge_q + 2'd1;
        state_d = ptcp_pkg::S_ESET;
      end
      ptcp_pkg::S_FIN: begin
        if (!ovld_q || m_axis_tready) begin
          out_d   = {1'b0, bestd_q, best_q[2], best_q[1], best_q[0]};
          ovld_d  = 1'b1;
          state_d = ptcp_pkg::S_IDLE;
        end
      end
      default: begin
        if (cnt_q != nops) begin
          cnt_d = cnt_q + 3'd1;
        end else begin
          cnt_d = '0;
          unique case (state_q)
            ptcp_pkg::S_CRN:  state_d = ptcp_pkg::S_DNN;
            ptcp_pkg::S_DNN: begin
              den_d   = dsum;
              state_d = ptcp_pkg::S_DWN;
            end
            ptcp_pkg::S_DWN: begin
              num_d   = dsum;
              state_d = (!den_q[65] && (den_q != 66'sd0)) ? ptcp_pkg::S_DIVT
                                                           : ptcp_pkg::S_FIN;
            end
            ptcp_pkg::S_PROJ: state_d = ptcp_pkg::S_SQP;
            ptcp_pkg::S_SQP:  state_d = ptcp_pkg::S_CHK;
            ptcp_pkg::S_CRE:  state_d = ptcp_pkg::S_DCN;
            ptcp_pkg::S_DCN: begin
              if (dsum[65]) begin
                outs_d  = outs_q + 2'd1;
                state_d = ptcp_pkg::S_DLL;
              end else begin
                edge_d  = edge_q + 2'd1;
                state_d = ptcp_pkg::S_ESET;
              end
            end
            ptcp_pkg::S_DLL: begin
              lensq_d = dsum;
              state_d = ptcp_pkg::S_DLR;
            end
            ptcp_pkg::S_DLR: begin
              numer_d = dsum;
              if (lensq_q[65] || (lensq_q == 66'sd0) || dsum[65] || (dsum == 66'sd0)) begin
                prm_d   = '0;
                state_d = ptcp_pkg::S_EPT;
              end else if (dsum >= lensq_q) begin
                prm_d   = ONE;
                state_d = ptcp_pkg::S_EPT;
              end else begin
                state_d = ptcp_pkg::S_DIVP;
              end
            end
            ptcp_pkg::S_EPT:  state_d = ptcp_pkg::S_SQD;
            default:          state_d = ptcp_pkg::S_UPD;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptcp_pkg::S_IDLE;
      cnt_q   <= '0;
      edge_q  <= '0;
      outs_q  <= '0;
      ovld_q  <= 1'b0;
      qr_q    <= '{default: '0};
      sr_q    <= '{default: '0};
      sd_q    <= ptcp_pkg::DMAX;
      best_q  <= '{default: '0};
      bestd_q <= ptcp_pkg::DMAX;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      edge_q  <= edge_d;
      outs_q  <= outs_d;
      ovld_q  <= ovld_d;
      qr_q    <= qr_d;
      sr_q    <= sr_d;
      sd_q    <= sd_d;
      best_q  <= best_d;
      bestd_q <= bestd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q <= va_d;  vb_q <= vb_d;  vc_q <= vc_d;
    ab_q <= ab_d;  ac_q <= ac_d;  w_q <= w_d;  n_q <= n_d;
    proj_q <= proj_d;  p_q <= p_d;  v1_q <= v1_d;  v2_q <= v2_d;
    e1_q <= e1_d;  e2_q <= e2_d;  cr_q <= cr_d;  ln_q <= ln_d;  rel_q <= rel_d;
    c_q <= c_d;  t_q <= t_d;  prm_q <= prm_d;  acc_q <= acc_d;
    den_q <= den_d;  num_q <= num_d;  lensq_q <= lensq_d;  numer_q <= numer_d;
    plane_q <= plane_d;  sqacc_q <= sqacc_d;  out_q <= out_d;
  end

  assign s_axis_tready = (state_q == ptcp_pkg::S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: hdl/ptcp_checker.sv
// Port-level checks of the closest point unit, bound to the top level.
// Depends on point_triangle_closest_point_unit_defines.svh.
`timescale 1ns / 1ps
`include "point_triangle_closest_point_unit_defines.svh"

module ptcp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata
);

  `PTCP_ASSERT_ALWAYS(a_rst_no_word, !rst_ni |-> !m_axis_tvalid, "result valid in reset")
  `PTCP_ASSERT(a_busy_after_in, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready while busy")
  `PTCP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result word dropped")
  `PTCP_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result word changed")

endmodule

bind point_triangle_closest_point_unit ptcp_checker u_ptcp_checker (.*);
